// ===== rtl/rtp_stk_pkg.sv =====
// Package for the RTP stream sequence tracker.
// Holds payload structs, the per-stream record type, sequencer states and helpers.
// No dependencies.
`default_nettype none

package rtp_stk_pkg;

    localparam int STREAM_SLOTS_DEF = 64;
    localparam int SEQ_W            = 16;
    localparam int CNT_W            = 32;
    localparam int SLOT_W           = 6;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [15:0] HDR_MIN_BYTES = 16'd12;
    localparam logic [1:0]  RTP_V2        = 2'd2;

    typedef struct packed {
        logic [1:0]  rtp_version;
        logic [6:0]  media_kind;
        logic [15:0] sequence_req;
        logic [31:0] source_id;
        logic [15:0] packet_bytes;
    } t_in;

    typedef struct packed {
        logic              accepted;
        logic              new_entry;
        logic              table_full;
        logic [SLOT_W-1:0] slot;
        logic              duplicate_seen;
        logic              gap_seen;
        logic [CNT_W-1:0]  packets_total;
        logic [CNT_W-1:0]  gaps_total;
        logic [CNT_W-1:0]  duplicates_total;
    } t_out;

    // classified header as it waits between front and back
    typedef struct packed {
        logic hdr_ok;
        t_in  hdr;
    } t_qitem;

    // per-stream record kept in RAM next to the key
    typedef struct packed {
        logic [SEQ_W-1:0] prev_seq;
        logic             armed;
        logic [CNT_W-1:0] pkt_cnt;
        logic [CNT_W-1:0] gap_cnt;
        logic [CNT_W-1:0] dup_cnt;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_CMP,
        S_REC,
        S_OUT
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rtp_stk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rtp_stk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/rtp_stk_front.sv =====
// Front end: takes headers, checks length and version, queues them for the back end.
// Depends on rtp_stk_pkg.
`default_nettype none

module rtp_stk_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire rtp_stk_pkg::t_in      i_in_data,
    output logic                       o_q_valid,
    input  wire logic                  i_q_pop,
    output rtp_stk_pkg::t_qitem        o_q_data
);

    localparam int QD  = rtp_stk_pkg::QUEUE_DEPTH;
    localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    rtp_stk_pkg::t_qitem r_q [QD];
    logic [QPW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           push;
    rtp_stk_pkg::t_qitem item;

    assign o_in_ready = (r_cnt != QCW'(QD));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_data   = r_q[r_rp];

    always_comb begin
        item.hdr    = i_in_data;
        item.hdr_ok = (i_in_data.packet_bytes >= rtp_stk_pkg::HDR_MIN_BYTES) &&
                      (i_in_data.rtp_version == rtp_stk_pkg::RTP_V2);
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPW'(QD - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_q_pop && o_q_valid) begin
            n_rp = (r_rp == QPW'(QD - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !(i_q_pop && o_q_valid)) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_q_pop && o_q_valid) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rtp_stk_back.sv =====
// Back end: scans the stream key RAM, updates the stream record, holds the result.
// Depends on rtp_stk_pkg and rtp_stk_ram.
`default_nettype none

module rtp_stk_back #(
    parameter int STREAM_SLOTS = rtp_stk_pkg::STREAM_SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    output logic                       o_q_pop,
    input  wire rtp_stk_pkg::t_qitem   i_q_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output rtp_stk_pkg::t_out          o_out_data
);

    localparam int IW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int CW = $clog2(STREAM_SLOTS + 1);
    localparam int RW = $bits(rtp_stk_pkg::t_rec);

    rtp_stk_pkg::t_state r_state, n_state;
    rtp_stk_pkg::t_qitem r_item, n_item;
    rtp_stk_pkg::t_out   r_res, n_res;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_count, n_count;

    logic                key_we, rec_we;
    logic [IW-1:0]       waddr;
    logic [31:0]         key_rdata;
    logic [RW-1:0]       rec_rdata_raw;
    rtp_stk_pkg::t_rec   rec_rd, rec_wr;
    logic                at_end, tbl_full, key_hit;

    assign rec_rd   = rec_rdata_raw;
    assign at_end   = (r_idx == r_count);
    assign tbl_full = (r_count >= CW'(STREAM_SLOTS));
    assign key_hit  = (key_rdata == r_item.hdr.source_id);

    rtp_stk_ram #(.WIDTH(32), .DEPTH(STREAM_SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (r_item.hdr.source_id),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (key_rdata)
    );

    rtp_stk_ram #(.WIDTH(RW), .DEPTH(STREAM_SLOTS)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (waddr),
        .i_wdata (rec_wr),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rec_rdata_raw)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rtp_stk_pkg::S_IDLE: begin
                if (i_q_valid) n_state = rtp_stk_pkg::S_CHK;
            end
            rtp_stk_pkg::S_CHK: begin
                if (!r_item.hdr_ok || at_end) n_state = rtp_stk_pkg::S_OUT;
                else                          n_state = rtp_stk_pkg::S_CMP;
            end
            rtp_stk_pkg::S_CMP: begin
                n_state = key_hit ? rtp_stk_pkg::S_REC : rtp_stk_pkg::S_CHK;
            end
            rtp_stk_pkg::S_REC: n_state = rtp_stk_pkg::S_OUT;
            rtp_stk_pkg::S_OUT: begin
                if (i_out_ready) n_state = rtp_stk_pkg::S_IDLE;
            end
            default: n_state = rtp_stk_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_item      = r_item;
        n_idx       = r_idx;
        n_count     = r_count;
        n_res       = r_res;
        o_q_pop     = 1'b0;
        o_out_valid = 1'b0;
        key_we      = 1'b0;
        rec_we      = 1'b0;
        waddr       = r_idx[IW-1:0];
        rec_wr      = rec_rd;
        case (r_state)
            rtp_stk_pkg::S_IDLE: begin
                o_q_pop = i_q_valid;
                n_item  = i_q_data;
                n_idx   = '0;
            end
            rtp_stk_pkg::S_CHK: begin
                n_res = '0;
                if (r_item.hdr_ok && at_end) begin
                    // no key matched: claim the next free entry, if any
                    n_res.accepted = 1'b1;
                    if (tbl_full) begin
                        n_res.table_full = 1'b1;
                    end else begin
                        waddr           = r_count[IW-1:0];
                        key_we          = 1'b1;
                        rec_we          = 1'b1;
                        rec_wr.prev_seq = r_item.hdr.sequence_req;
                        rec_wr.armed    = 1'b0;
                        rec_wr.pkt_cnt  = rtp_stk_pkg::CNT_W'(1);
                        rec_wr.gap_cnt  = '0;
                        rec_wr.dup_cnt  = '0;
                        n_count         = r_count + 1'b1;
                        n_res.new_entry     = 1'b1;
                        n_res.slot          = rtp_stk_pkg::SLOT_W'(r_count);
                        n_res.packets_total = rtp_stk_pkg::CNT_W'(1);
                    end
                end
            end
            rtp_stk_pkg::S_CMP: begin
                if (!key_hit) n_idx = r_idx + 1'b1;
            end
            rtp_stk_pkg::S_REC: begin
                rec_wr.prev_seq = r_item.hdr.sequence_req;
                rec_wr.armed    = 1'b1;
                rec_wr.pkt_cnt  = rtp_stk_pkg::sat_inc(rec_rd.pkt_cnt);
                n_res.accepted  = 1'b1;
                n_res.slot      = rtp_stk_pkg::SLOT_W'(r_idx);
                if (rec_rd.armed && rec_rd.prev_seq == r_item.hdr.sequence_req) begin
                    n_res.duplicate_seen = 1'b1;
                    rec_wr.dup_cnt = rtp_stk_pkg::sat_inc(rec_rd.dup_cnt);
                end
                if (rec_rd.armed &&
                    (rec_rd.prev_seq + 1'b1) != r_item.hdr.sequence_req) begin
                    n_res.gap_seen = 1'b1;
                    rec_wr.gap_cnt = rtp_stk_pkg::sat_inc(rec_rd.gap_cnt);
                end
                n_res.packets_total    = rec_wr.pkt_cnt;
                n_res.gaps_total       = rec_wr.gap_cnt;
                n_res.duplicates_total = rec_wr.dup_cnt;
                rec_we = 1'b1;
            end
            rtp_stk_pkg::S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_out_data = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtp_stk_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_item <= n_item;
        r_idx  <= n_idx;
        r_res  <= n_res;
    end

endmodule

`default_nettype wire

// ===== rtl/rtp_stream_sequence_tracker_core.sv =====
// Top level of the RTP stream sequence tracker: header front end, queue, lookup back end.
// Depends on rtp_stk_pkg, rtp_stk_front, rtp_stk_back.
//
//   channel | handshake                   | payload
//   input   | i_in_valid / o_in_ready     | i_in_data   (rtp_stk_pkg::t_in)
//   output  | o_out_valid / i_out_ready   | o_out_data  (rtp_stk_pkg::t_out)
//
// A header whose id matches entry k is found by scanning key RAM entries 0 to k, one
// entry per pass through S_CHK and S_CMP; a new id scans every filled entry first.
// Invalid headers skip the scan. The result is held in S_OUT until i_out_ready is high.
// A 2-deep queue keeps input transfers going while a result waits. Reset is synchronous
// and needs no clearing pass; entries are tracked by a fill count.
`default_nettype none

module rtp_stream_sequence_tracker_core #(
    parameter int STREAM_SLOTS = rtp_stk_pkg::STREAM_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rtp_stk_pkg::t_in   i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rtp_stk_pkg::t_out       o_out_data
);

    logic                q_valid, q_pop;
    rtp_stk_pkg::t_qitem q_data;

    rtp_stk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_data   (q_data)
    );

    rtp_stk_back #(.STREAM_SLOTS(STREAM_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_data    (q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for rtp_stream_sequence_tracker_core: directed header table, then random traffic.
// Results are checked field by field against an in-bench stream table predictor.
// Depends on rtp_stk_pkg and the tracker RTL.
`default_nettype none

module testbench;

    localparam int STREAMS     = 64;
    localparam int RAND_ITEMS  = 1000;
    localparam int DRAIN_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    rtp_stk_pkg::t_in  i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    rtp_stk_pkg::t_out o_out_data;

    rtp_stream_sequence_tracker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // predictor copy of the stream table
    int          tracked_entries;
    logic [31:0] stream_ssrc [STREAMS];
    logic [15:0] stream_seq  [STREAMS];
    logic        stream_armed[STREAMS];
    logic [31:0] stream_pkts [STREAMS];
    logic [31:0] stream_gaps [STREAMS];
    logic [31:0] stream_dups [STREAMS];

    rtp_stk_pkg::t_out pending_results[$];
    int   error_count;
    int   results_seen;
    int   full_seen;
    int   gap_seen_cnt;
    int   dup_seen_cnt;
    int   invalid_seen;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic rtp_stk_pkg::t_out track_header(input rtp_stk_pkg::t_in h);
        rtp_stk_pkg::t_out r;
        logic [15:0] nxt;
        r = '0;
        if (h.packet_bytes < 16'd12 || h.rtp_version != 2'd2) return r;
        r.accepted = 1'b1;
        for (int i = 0; i < tracked_entries; i++) begin
            if (stream_ssrc[i] == h.source_id) begin
                if (stream_armed[i]) begin
                    nxt = stream_seq[i] + 16'd1;
                    if (stream_seq[i] == h.sequence_req) begin
                        r.duplicate_seen = 1'b1;
                        stream_dups[i] = bump(stream_dups[i]);
                    end
                    if (nxt != h.sequence_req) begin
                        r.gap_seen = 1'b1;
                        stream_gaps[i] = bump(stream_gaps[i]);
                    end
                end
                stream_seq[i]      = h.sequence_req;
                stream_armed[i]    = 1'b1;
                stream_pkts[i]     = bump(stream_pkts[i]);
                r.slot             = i[5:0];
                r.packets_total    = stream_pkts[i];
                r.gaps_total       = stream_gaps[i];
                r.duplicates_total = stream_dups[i];
                return r;
            end
        end
        if (tracked_entries >= STREAMS) begin
            r.table_full = 1'b1;
            return r;
        end
        stream_ssrc[tracked_entries]  = h.source_id;
        stream_seq[tracked_entries]   = h.sequence_req;
        stream_armed[tracked_entries] = 1'b0;
        stream_pkts[tracked_entries]  = 32'd1;
        stream_gaps[tracked_entries]  = 32'd0;
        stream_dups[tracked_entries]  = 32'd0;
        r.new_entry     = 1'b1;
        r.slot          = tracked_entries[5:0];
        r.packets_total = 32'd1;
        tracked_entries++;
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, field, got, exp);
        error_count++;
    endtask

    // sender burst state
    int burst_left;

    task automatic send_header(input rtp_stk_pkg::t_in h, input bit has_exp,
                               input rtp_stk_pkg::t_out exp);
        rtp_stk_pkg::t_out pred;
        if (burst_left == 0) begin
            if (i_in_valid) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= h;
        do @(posedge i_clk); while (!o_in_ready);
        pred = track_header(h);
        pending_results.push_back(has_exp ? exp : pred);
        burst_left--;
    endtask

    function automatic rtp_stk_pkg::t_in make_header(input logic [1:0] ver,
                                                     input logic [15:0] seq,
                                                     input logic [31:0] id,
                                                     input logic [15:0] bytes);
        rtp_stk_pkg::t_in h;
        h.rtp_version  = ver;
        h.media_kind   = 7'($urandom);
        h.sequence_req = seq;
        h.source_id    = id;
        h.packet_bytes = bytes;
        return h;
    endfunction

    function automatic rtp_stk_pkg::t_out make_fresh(input logic [5:0] slot);
        rtp_stk_pkg::t_out r;
        r = '0;
        r.accepted      = 1'b1;
        r.new_entry     = 1'b1;
        r.slot          = slot;
        r.packets_total = 32'd1;
        return r;
    endfunction

    typedef struct {
        rtp_stk_pkg::t_in  hdr;
        bit                has_exp;
        rtp_stk_pkg::t_out exp;
    } t_row;

    t_row rows[$];

    function automatic rtp_stk_pkg::t_in random_header(input int idx);
        rtp_stk_pkg::t_in h;
        int   pick;
        int   k;
        h = '{rtp_version: 2'd2, media_kind: 7'($urandom), sequence_req: 16'($urandom),
              source_id: $urandom, packet_bytes: 16'($urandom_range(12, 65535))};
        // fill the table early so the full-table path gets plenty of traffic
        if (idx < 70) return h;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            h.rtp_version  = 2'($urandom);
            h.packet_bytes = (pick < 4) ? 16'($urandom_range(0, 11)) : 16'($urandom);
        end else if (pick >= 14 && tracked_entries > 0) begin
            k = $urandom_range(0, tracked_entries - 1);
            h.source_id = stream_ssrc[k];
            pick = $urandom_range(0, 9);
            if (pick < 7)      h.sequence_req = stream_seq[k] + 16'd1;
            else if (pick < 8) h.sequence_req = stream_seq[k];
        end
        return h;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern: random stretches, each either free-running or choppy
    initial begin
        int mode_len;
        int choppy;
        i_out_ready = 1'b0;
        forever begin
            mode_len = $urandom_range(5, 60);
            choppy   = $urandom_range(0, 2);
            repeat (mode_len) begin
                @(negedge i_clk);
                i_out_ready <= (choppy == 0) ? 1'b1 : ($urandom_range(0, choppy) == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        rtp_stk_pkg::t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result transfer");
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_out_data.accepted !== e.accepted)
                    report("accepted", o_out_data.accepted, e.accepted);
                if (o_out_data.new_entry !== e.new_entry)
                    report("new_entry", o_out_data.new_entry, e.new_entry);
                if (o_out_data.table_full !== e.table_full)
                    report("table_full", o_out_data.table_full, e.table_full);
                if (o_out_data.slot !== e.slot)
                    report("slot", o_out_data.slot, e.slot);
                if (o_out_data.duplicate_seen !== e.duplicate_seen)
                    report("duplicate_seen", o_out_data.duplicate_seen, e.duplicate_seen);
                if (o_out_data.gap_seen !== e.gap_seen)
                    report("gap_seen", o_out_data.gap_seen, e.gap_seen);
                if (o_out_data.packets_total !== e.packets_total)
                    report("packets_total", o_out_data.packets_total, e.packets_total);
                if (o_out_data.gaps_total !== e.gaps_total)
                    report("gaps_total", o_out_data.gaps_total, e.gaps_total);
                if (o_out_data.duplicates_total !== e.duplicates_total)
                    report("duplicates_total", o_out_data.duplicates_total,
                           e.duplicates_total);
                results_seen++;
                full_seen    += e.table_full;
                gap_seen_cnt += e.gap_seen;
                dup_seen_cnt += e.duplicate_seen;
                invalid_seen += !e.accepted;
            end
        end
    end

    initial begin
        #20000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        tracked_entries = 0;
        error_count  = 0;
        results_seen = 0;
        full_seen    = 0;
        gap_seen_cnt = 0;
        dup_seen_cnt = 0;
        invalid_seen = 0;
        burst_left   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // invalid headers: short, empty, wrong versions
        rows.push_back('{make_header(2'd2, 16'h1234, 32'hA5A5_0001, 16'd11), 1, '0});
        rows.push_back('{make_header(2'd2, 16'h0000, 32'h0000_0000, 16'd0), 1, '0});
        rows.push_back('{make_header(2'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF), 1, '0});
        rows.push_back('{make_header(2'd1, 16'h0001, 32'h1111_1111, 16'd100), 1, '0});
        rows.push_back('{make_header(2'd3, 16'h8000, 32'h2222_2222, 16'd12), 1, '0});
        // new entries at the field extremes
        rows.push_back('{make_header(2'd2, 16'hFFFE, 32'h0000_0000, 16'd12), 1, make_fresh(6'd0)});
        rows.push_back('{make_header(2'd2, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF), 1,
                         make_fresh(6'd1)});
        rows[6].hdr.media_kind = 7'h7F;
        rows[5].hdr.media_kind = 7'h00;
        // unarmed entry only arms, then in-order, wrap, duplicate, gap
        rows.push_back('{make_header(2'd2, 16'h0005, 32'h0000_0000, 16'd40), 0, '0});
        rows.push_back('{make_header(2'd2, 16'h0006, 32'h0000_0000, 16'd40), 0, '0});
        rows.push_back('{make_header(2'd2, 16'h0006, 32'h0000_0000, 16'd40), 0, '0});
        rows.push_back('{make_header(2'd2, 16'h0100, 32'h0000_0000, 16'd40), 0, '0});
        rows.push_back('{make_header(2'd2, 16'hFFFF, 32'hFFFF_FFFF, 16'd20), 0, '0});
        rows.push_back('{make_header(2'd2, 16'hFFFF, 32'hFFFF_FFFF, 16'd20), 0, '0});
        rows.push_back('{make_header(2'd2, 16'h0000, 32'hFFFF_FFFF, 16'd20), 0, '0});
        rows.push_back('{make_header(2'd2, 16'h0001, 32'hFFFF_FFFF, 16'd20), 0, '0});
        rows.push_back('{make_header(2'd2, 16'h0003, 32'hFFFF_FFFF, 16'd20), 0, '0});
        // an invalid header with a known id must not touch its entry
        rows.push_back('{make_header(2'd1, 16'h0004, 32'hFFFF_FFFF, 16'd20), 1, '0});
        rows.push_back('{make_header(2'd2, 16'h0004, 32'hFFFF_FFFF, 16'd20), 0, '0});
        rows.push_back('{make_header(2'd2, 16'h5555, 32'h5555_AAAA, 16'd13), 1, make_fresh(6'd2)});

        foreach (rows[i]) send_header(rows[i].hdr, rows[i].has_exp, rows[i].exp);
        for (int n = 0; n < RAND_ITEMS; n++) send_header(random_header(n), 0, '0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);

        $display("%0d results checked: %0d invalid, %0d table full, %0d gaps, %0d duplicates",
                 results_seen, invalid_seen, full_seen, gap_seen_cnt, dup_seen_cnt);
        $display("%0d streams tracked, %0d mismatches", tracked_entries, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
